[sv/rrca_pkg.sv]
// Shared types, constants and result builders for the reorder receiver.
package rrca_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int SEG_MAX   = 1024;
    localparam int DROP_LIST = 4;
    localparam int DROP_W    = 2;
    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int PER_W     = 16;
    localparam int CNT_W     = 3;

    localparam int SQ_DEPTH  = 2;
    localparam int SQ_AW     = 1;
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_AW     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOSS_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_AT_0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_AT_1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_AT_2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_AT_3   = 3'd6;

    localparam logic [1:0] LOSS_NONE     = 2'd0;
    localparam logic [1:0] LOSS_PERIODIC = 2'd1;
    localparam logic [1:0] LOSS_LISTED   = 2'd2;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic             fin;
    } t_seg;

    typedef struct packed {
        logic             kind;
        logic [SEQ_W-1:0] deliver_start;
        logic [LEN_W-1:0] deliver_len;
        logic [SEQ_W-1:0] echo_seq;
        logic [SEQ_W-1:0] ack_next;
        logic             stream_done;
        logic             store_full;
        logic             last;
    } t_res;

    function automatic t_res mk_deliver(logic [SEQ_W-1:0] start, logic [LEN_W-1:0] len);
        t_res r;
        r               = '0;
        r.kind          = KIND_DELIVER;
        r.deliver_start = start;
        r.deliver_len   = len;
        return r;
    endfunction

    function automatic t_res mk_ack(logic [SEQ_W-1:0] echo, logic [SEQ_W-1:0] next,
                                    logic done, logic full);
        t_res r;
        r             = '0;
        r.kind        = KIND_ACK;
        r.echo_seq    = echo;
        r.ack_next    = next;
        r.stream_done = done;
        r.store_full  = full;
        r.last        = 1'b1;
        return r;
    endfunction

endpackage

[sv/reorder_receive_with_cumulative_ack.sv]
// A request reaches the segment queue on its accept edge; the back end then writes an old or
// early segment's ack, or an in-order one's delivery, into the result queue. It writes one
// result per cycle while the result queue has room; an in-order segment adds one delivery per
// slot drained by the drain walk and a closing ack, and no new segment is popped until it ends.
// A loss_period write runs a bit-serial remainder recompute with full held high.
// Reset (synchronous, active low) empties both queues, clears all slots and counters.
module reorder_receive_with_cumulative_ack import rrca_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic [SEQ_W-1:0]     i_seg_seq,
    input  logic [LEN_W-1:0]     i_seg_len,
    input  logic                 i_seg_fin,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_kind,
    output logic [SEQ_W-1:0]     o_deliver_start,
    output logic [LEN_W-1:0]     o_deliver_len,
    output logic [SEQ_W-1:0]     o_echo_seq,
    output logic [SEQ_W-1:0]     o_ack_next,
    output logic                 o_stream_done,
    output logic                 o_store_full,
    output logic                 o_last
);

    t_seg in_seg;
    t_seg front_seg;
    t_seg q_seg;
    t_res res;
    logic front_busy;
    logic front_wr;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign in_seg.seq = i_seg_seq;
    assign in_seg.len = i_seg_len;
    assign in_seg.fin = i_seg_fin;
    assign full       = front_busy || q_full;
    assign accept     = push && !full;

    rrca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_seg       (in_seg),
        .o_busy      (front_busy),
        .o_wr        (front_wr),
        .o_seg       (front_seg)
    );

    rrca_segq u_segq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_wr),
        .i_seg   (front_seg),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_empty (q_empty),
        .o_seg   (q_seg)
    );

    rrca_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (q_seg),
        .i_seg_empty (q_empty),
        .o_seg_pop   (q_pop),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_kind          = res.kind;
    assign o_deliver_start = res.deliver_start;
    assign o_deliver_len   = res.deliver_len;
    assign o_echo_seq      = res.echo_seq;
    assign o_ack_next      = res.ack_next;
    assign o_stream_done   = res.stream_done;
    assign o_store_full    = res.store_full;
    assign o_last          = res.last;

    a_period_recompute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == REG_LOSS_PERIOD)) |=> full)
        else $error("loss_period write did not hold off requests");

    a_delivery_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_DELIVER)) |->
            (!o_last && (o_echo_seq == '0) && (o_ack_next == '0) && !o_store_full))
        else $error("delivery result carries ack fields");

    a_len_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_deliver_len <= LEN_W'(SEG_MAX)))
        else $error("delivered length above maximum segment size");

endmodule

[sv/rrca_front.sv]
// Front end: configuration registers, arrival counter and loss injection.
module rrca_front import rrca_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_accept,
    input  t_seg                 i_seg,
    output logic                 o_busy,
    output logic                 o_wr,
    output t_seg                 o_seg
);

    logic [1:0]       r_mode;
    logic [PER_W-1:0] r_period;
    logic [CNT_W-1:0] r_drop_cnt;
    logic [SEQ_W-1:0] r_drop_at [DROP_LIST];
    logic [SEQ_W-1:0] r_arr;
    logic [PER_W:0]   r_rem;
    logic [CNT_W-1:0] r_drop_idx;
    logic             r_busy;
    logic [4:0]       r_step;

    logic [PER_W-1:0] eff_period;
    logic [PER_W:0]   divisor;
    logic [SEQ_W-1:0] n_arr;
    logic [PER_W:0]   n_rem;
    logic [CNT_W-1:0] drop_n;
    logic             list_hit;
    logic             per_hit;
    logic [PER_W+1:0] trial;
    logic             trial_ge;

    assign eff_period = (r_period < PER_W'(2)) ? PER_W'(2) : r_period;
    assign divisor    = {1'b0, eff_period} + (PER_W+1)'(1);
    assign n_arr      = r_arr + SEQ_W'(1);
    // Running remainder of the arrival count; restart it when the count wraps.
    assign n_rem      = (n_arr == '0) ? '0 :
                        (r_rem == divisor - (PER_W+1)'(1)) ? '0 : r_rem + (PER_W+1)'(1);
    assign drop_n     = (r_drop_cnt > CNT_W'(DROP_LIST)) ? CNT_W'(DROP_LIST) : r_drop_cnt;
    assign list_hit   = (r_mode == LOSS_LISTED) && (r_drop_idx < drop_n) &&
                        (n_arr == r_drop_at[r_drop_idx[DROP_W-1:0]]);
    assign per_hit    = (r_mode == LOSS_PERIODIC) && ((n_arr == SEQ_W'(1)) || (n_rem == '0));

    assign trial    = {r_rem, r_arr[~r_step]};
    assign trial_ge = trial >= {1'b0, divisor};

    assign o_busy      = r_busy;
    assign o_wr        = i_accept && !per_hit && !list_hit;
    assign o_seg.seq   = i_seg.seq;
    assign o_seg.len   = (i_seg.len > LEN_W'(SEG_MAX)) ? LEN_W'(SEG_MAX) : i_seg.len;
    assign o_seg.fin   = i_seg.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= LOSS_NONE;
            r_period   <= PER_W'(2);
            r_drop_cnt <= '0;
            for (int i = 0; i < DROP_LIST; i++) begin
                r_drop_at[i] <= SEQ_W'(1);
            end
            r_arr      <= '0;
            r_rem      <= '0;
            r_drop_idx <= '0;
            r_busy     <= 1'b0;
            r_step     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LOSS_MODE:   r_mode     <= i_cfg_wdata[1:0];
                    REG_LOSS_PERIOD: begin
                        r_period <= i_cfg_wdata[PER_W-1:0];
                        // recompute the remainder against the new period
                        r_busy   <= 1'b1;
                        r_step   <= '0;
                        r_rem    <= '0;
                    end
                    REG_DROP_COUNT:  r_drop_cnt <= i_cfg_wdata[CNT_W-1:0];
                    REG_DROP_AT_0:   r_drop_at[0] <= i_cfg_wdata;
                    REG_DROP_AT_1:   r_drop_at[1] <= i_cfg_wdata;
                    REG_DROP_AT_2:   r_drop_at[2] <= i_cfg_wdata;
                    REG_DROP_AT_3:   r_drop_at[3] <= i_cfg_wdata;
                    default: ;
                endcase
            end else if (r_busy) begin
                // one restoring division step per cycle while no config write comes in, MSB first
                r_rem  <= trial_ge ? (PER_W+1)'(trial - {1'b0, divisor})
                                   : trial[PER_W:0];
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end else if (i_accept) begin
                r_arr <= n_arr;
                r_rem <= n_rem;
                if (list_hit) begin
                    r_drop_idx <= r_drop_idx + CNT_W'(1);
                end
            end
        end
    end

endmodule

[sv/rrca_segq.sv]
// Short queue of accepted segment requests that survive loss injection, between the front and back ends.
module rrca_segq import rrca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_seg i_seg,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_seg o_seg
);

    t_seg             r_q [SQ_DEPTH];
    logic [SQ_AW-1:0] r_wp;
    logic [SQ_AW-1:0] r_rp;
    logic [SQ_AW:0]   r_cnt;

    logic wr_en;
    logic rd_en;

    assign o_full  = (r_cnt == (SQ_AW+1)'(SQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_seg   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + SQ_AW'(1);
            end
            if (rd_en) begin
                r_rp <= r_rp + SQ_AW'(1);
            end
            r_cnt <= r_cnt + (SQ_AW+1)'(wr_en) - (SQ_AW+1)'(rd_en);
        end
    end

endmodule

[sv/rrca_back.sv]
// Back end: slot table, in-order delivery, drain walk and result queue.
module rrca_back import rrca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_seg i_seg,
    input  logic i_seg_empty,
    output logic o_seg_pop,
    output t_res o_res,
    output logic o_empty,
    input  logic i_pop
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             r_state;
    logic [SEQ_W-1:0] r_delivered;
    logic             r_fin_seen;
    logic [SLOTS-1:0] r_valid;
    logic [SEQ_W-1:0] r_sseq [SLOTS];
    logic [LEN_W-1:0] r_slen [SLOTS];
    logic             r_sfin [SLOTS];
    logic [SEQ_W-1:0] r_cur_seq;

    t_res             r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp;
    logic [OQ_AW-1:0] r_rp;
    logic [OQ_AW:0]   r_cnt;

    logic              n_state;
    logic [SEQ_W-1:0]  n_delivered;
    logic              n_fin_seen;
    logic [SLOTS-1:0]  n_valid;
    logic [SEQ_W-1:0]  expect_seq;
    logic              hit_any;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    logic              st_any;
    logic [SLOT_W-1:0] st_idx;
    logic              m_any;
    logic [SLOT_W-1:0] m_idx;
    logic              room;
    logic              store_we;
    logic              oq_wr;
    logic              oq_rd;
    t_res              oq_wdata;

    assign expect_seq = r_delivered + SEQ_W'(1);
    assign room       = (r_cnt != (OQ_AW+1)'(OQ_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign oq_rd      = i_pop && !o_empty;
    assign o_res      = r_oq[r_rp];

    // Parallel compare over the slots; the descending walk leaves the lowest index.
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        m_any    = 1'b0;
        m_idx    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_sseq[i] == i_seg.seq)) begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (r_valid[i] && (r_sseq[i] == expect_seq)) begin
                m_any = 1'b1;
                m_idx = SLOT_W'(i);
            end
        end
        st_any = hit_any || free_any;
        st_idx = hit_any ? hit_idx : free_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_delivered = r_delivered;
        n_fin_seen  = r_fin_seen;
        n_valid     = r_valid;
        o_seg_pop   = 1'b0;
        store_we    = 1'b0;
        oq_wr       = 1'b0;
        oq_wdata    = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_seg_empty && room) begin
                    o_seg_pop = 1'b1;
                    oq_wr     = 1'b1;
                    if (i_seg.seq > expect_seq) begin
                        // early: park it, flag the ack if no slot is left
                        store_we = st_any;
                        if (st_any) begin
                            n_valid[st_idx] = 1'b1;
                        end
                        oq_wdata = mk_ack(i_seg.seq, expect_seq, r_fin_seen, !st_any);
                    end else if (i_seg.seq == expect_seq) begin
                        oq_wdata    = mk_deliver(i_seg.seq, i_seg.len);
                        n_delivered = r_delivered + {{(SEQ_W-LEN_W){1'b0}}, i_seg.len};
                        n_fin_seen  = r_fin_seen || i_seg.fin;
                        n_state     = ST_DRAIN;
                    end else begin
                        oq_wdata = mk_ack(i_seg.seq, expect_seq, r_fin_seen, 1'b0);
                    end
                end
            end
            ST_DRAIN: begin
                if (room) begin
                    oq_wr = 1'b1;
                    if (m_any) begin
                        oq_wdata       = mk_deliver(r_sseq[m_idx], r_slen[m_idx]);
                        n_delivered    = r_delivered +
                                         {{(SEQ_W-LEN_W){1'b0}}, r_slen[m_idx]};
                        n_fin_seen     = r_fin_seen || r_sfin[m_idx];
                        n_valid[m_idx] = 1'b0;
                    end else begin
                        oq_wdata = mk_ack(r_cur_seq, expect_seq, r_fin_seen, 1'b0);
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_sseq[st_idx] <= i_seg.seq;
            r_slen[st_idx] <= i_seg.len;
            r_sfin[st_idx] <= i_seg.fin;
        end
        if (o_seg_pop) begin
            r_cur_seq <= i_seg.seq;
        end
        if (oq_wr) begin
            r_oq[r_wp] <= oq_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_delivered <= '0;
            r_fin_seen  <= 1'b0;
            r_valid     <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_delivered <= n_delivered;
            r_fin_seen  <= n_fin_seen;
            r_valid     <= n_valid;
            if (oq_wr) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (oq_rd) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + (OQ_AW+1)'(oq_wr) - (OQ_AW+1)'(oq_rd);
        end
    end

endmodule
